@@ rtl/core/evtr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtr_pkg
// Shared types, constants and the keycode table of the input to evdev
// translator.
// ----------------------------------------------------------------------------
package evtr_pkg;

    localparam int AXIS_W  = 16;
    localparam int KEY_W   = 7;
    localparam int CODE_W  = 9;
    localparam int VALUE_W = 17;
    localparam int WHEEL_W = 8;
    localparam int BTN_N   = 3;
    localparam int SCAN_W  = 16;

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    localparam int DIV_CYCLES = AXIS_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic REQ_KBD   = 1'b0;
    localparam logic REQ_MOUSE = 1'b1;

    localparam logic DEV_KBD = 1'b0;
    localparam logic DEV_PTR = 1'b1;

    localparam logic [1:0] EV_SYN = 2'd0;
    localparam logic [1:0] EV_KEY = 2'd1;
    localparam logic [1:0] EV_REL = 2'd2;
    localparam logic [1:0] EV_ABS = 2'd3;

    localparam logic [CODE_W-1:0] CODE_SYN_REPORT = 9'd0;
    localparam logic [CODE_W-1:0] CODE_ABS_X      = 9'd0;
    localparam logic [CODE_W-1:0] CODE_ABS_Y      = 9'd1;
    localparam logic [CODE_W-1:0] CODE_REL_WHEEL  = 9'd8;
    localparam logic [CODE_W-1:0] CODE_BTN_LEFT   = 9'h110;

    localparam logic [SCAN_W-1:0] LAST_DIRECT_KEY = 16'h0058;

    typedef struct packed {
        logic                        is_mouse;
        logic [KEY_W-1:0]            key_code;
        logic                        key_press;
        logic [AXIS_W-1:0]           pointer_x;
        logic [AXIS_W-1:0]           pointer_y;
        logic [BTN_N-1:0]            changed;
        logic [BTN_N-1:0]            buttons;
        logic signed [WHEEL_W-1:0]   wheel;
    } cmd_t;

    typedef struct packed {
        logic                        device_index;
        logic [1:0]                  event_type;
        logic [CODE_W-1:0]           event_code;
        logic signed [VALUE_W-1:0]   event_value;
        logic                        last_event;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [AXIS_W-1:0] pos;
        logic [AXIS_W-1:0] size;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [AXIS_W-1:0] quot;
    } div_rsp_t;

    // set-1 keycode to evdev key code, zero when unmapped
    function automatic logic [KEY_W-1:0] map_key(input logic [SCAN_W-1:0] code);
        logic [KEY_W-1:0] k;
        k = '0;
        if (code >= 16'd1 && code <= LAST_DIRECT_KEY)
        begin
            k = code[KEY_W-1:0];
        end
        else
        begin
            unique case (code)
                16'h0070: k = 7'd93;
                16'h0073: k = 7'd89;
                16'h0079: k = 7'd92;
                16'h007B: k = 7'd94;
                16'h007D: k = 7'd124;
                16'hE01C: k = 7'd96;
                16'hE01D: k = 7'd97;
                16'hE035: k = 7'd98;
                16'hE037: k = 7'd99;
                16'hE038: k = 7'd100;
                16'hE047: k = 7'd102;
                16'hE048: k = 7'd103;
                16'hE049: k = 7'd104;
                16'hE04B: k = 7'd105;
                16'hE04D: k = 7'd106;
                16'hE04F: k = 7'd107;
                16'hE050: k = 7'd108;
                16'hE051: k = 7'd109;
                16'hE052: k = 7'd110;
                16'hE053: k = 7'd111;
                16'hE05B: k = 7'd125;
                16'hE05C: k = 7'd126;
                16'hE05D: k = 7'd127;
                default:  k = '0;
            endcase
        end
        return k;
    endfunction

endpackage

@@ rtl/core/input_to_evdev_translator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_to_evdev_translator
// Translates keyboard and mouse words into runs of evdev event words.
//
//   channel   handshake                      payload
//   input     push / full                    req_type .. wheel_delta
//   result    empty / pop                    device_index .. last_event
//   config    psel penable pwrite pready     paddr, pwdata, prdata
//
// a mouse word waits in the back end on its two axis divisions,
// which run one after the other; a keyboard word needs no division
// an axis whose surface size is 0 or 1 skips its division
// reset clears queues, sequencer, divider and the stored button mask
// the command queue lets the front keep accepting while the back stalls on pop
// ----------------------------------------------------------------------------
module input_to_evdev_translator #(
    parameter int CMD_DEPTH = evtr_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = evtr_pkg::OUT_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 req_type,
    input  logic [evtr_pkg::SCAN_W-1:0]          scan_code,
    input  logic                                 key_press,
    input  logic [evtr_pkg::AXIS_W-1:0]          pointer_x,
    input  logic [evtr_pkg::AXIS_W-1:0]          pointer_y,
    input  logic [evtr_pkg::BTN_N-1:0]           button_mask,
    input  logic signed [evtr_pkg::WHEEL_W-1:0]  wheel_delta,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 device_index,
    output logic [1:0]                           event_type,
    output logic [evtr_pkg::CODE_W-1:0]          event_code,
    output logic signed [evtr_pkg::VALUE_W-1:0]  event_value,
    output logic                                 last_event,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [evtr_pkg::ADDR_W-1:0]          paddr,
    input  logic [evtr_pkg::DATA_W-1:0]          pwdata,
    output logic [evtr_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    import evtr_pkg::*;

    logic [AXIS_W-1:0] surface_width_reg;
    logic [AXIS_W-1:0] surface_height_reg;

    logic      cmd_push;
    cmd_t      cmd_wr;
    cmd_t      cmd_rd;
    logic      cmd_full;
    logic      cmd_empty;
    logic      cmd_pop;
    logic      out_push;
    logic      out_full;
    out_word_t out_wr;
    out_word_t out_rd;
    logic      cfg_wr;
    logic      reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];
    assign full    = cmd_full;

    always_comb
    begin
        prdata = '0;
        if (psel && !pwrite)
        begin
            unique case (reg_sel)
                REG_WIDTH:  prdata = {{(DATA_W - AXIS_W){1'b0}}, surface_width_reg};
                REG_HEIGHT: prdata = {{(DATA_W - AXIS_W){1'b0}}, surface_height_reg};
                default:    prdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= '0;
            surface_height_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_WIDTH)
            begin
                surface_width_reg <= pwdata[AXIS_W-1:0];
            end
            else
            begin
                surface_height_reg <= pwdata[AXIS_W-1:0];
            end
        end
    end

    evtr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .q_full      (cmd_full),
        .req_type    (req_type),
        .scan_code   (scan_code),
        .key_press   (key_press),
        .pointer_x   (pointer_x),
        .pointer_y   (pointer_y),
        .button_mask (button_mask),
        .wheel_delta (wheel_delta),
        .cmd_push    (cmd_push),
        .cmd         (cmd_wr)
    );

    evtr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wr),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rd),
        .empty (cmd_empty)
    );

    evtr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_empty      (cmd_empty),
        .cmd_in         (cmd_rd),
        .cmd_pop        (cmd_pop),
        .surface_width  (surface_width_reg),
        .surface_height (surface_height_reg),
        .out_full       (out_full),
        .out_push       (out_push),
        .out_word       (out_wr)
    );

    evtr_fifo #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wr),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rd),
        .empty (empty)
    );

    assign device_index = out_rd.device_index;
    assign event_type   = out_rd.event_type;
    assign event_code   = out_rd.event_code;
    assign event_value  = out_rd.event_value;
    assign last_event   = out_rd.last_event;

endmodule

@@ rtl/core/evtr_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtr_fifo
// Small register queue used between front and back end and at the output.
// ----------------------------------------------------------------------------
module evtr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/evtr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtr_front
// Accepts input words, translates keycodes, tracks the button mask and
// queues a command for each word that produces events.
// ----------------------------------------------------------------------------
module evtr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              q_full,
    input  logic                              req_type,
    input  logic [evtr_pkg::SCAN_W-1:0]       scan_code,
    input  logic                              key_press,
    input  logic [evtr_pkg::AXIS_W-1:0]       pointer_x,
    input  logic [evtr_pkg::AXIS_W-1:0]       pointer_y,
    input  logic [evtr_pkg::BTN_N-1:0]        button_mask,
    input  logic signed [evtr_pkg::WHEEL_W-1:0] wheel_delta,
    output logic                              cmd_push,
    output evtr_pkg::cmd_t                    cmd
);

    import evtr_pkg::*;

    logic [BTN_N-1:0] prev_buttons_reg;
    logic [KEY_W-1:0] key_code;
    logic             accept;
    logic             is_mouse;

    assign is_mouse = (req_type == REQ_MOUSE);
    assign key_code = map_key(scan_code);
    assign accept   = push && !q_full;
    assign cmd_push = accept && (is_mouse || key_code != '0);

    always_comb
    begin
        cmd.is_mouse  = is_mouse;
        cmd.key_code  = key_code;
        cmd.key_press = key_press;
        cmd.pointer_x = pointer_x;
        cmd.pointer_y = pointer_y;
        cmd.changed   = button_mask ^ prev_buttons_reg;
        cmd.buttons   = button_mask;
        cmd.wheel     = wheel_delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
        end
        else if (accept && is_mouse)
        begin
            prev_buttons_reg <= button_mask;
        end
    end

endmodule

@@ rtl/core/evtr_axis_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtr_axis_div
// Axis scaler: clamps the position and computes pos * 65535 / (size - 1)
// with a restoring divider retiring two quotient bits per cycle (zero for size 0 or 1).
// ----------------------------------------------------------------------------
module evtr_axis_div (
    input  logic               clk,
    input  logic               rst_n,
    input  evtr_pkg::div_req_t req,
    output evtr_pkg::div_rsp_t rsp
);

    import evtr_pkg::*;

    logic [AXIS_W-1:0]    rem_reg;
    logic [AXIS_W-1:0]    lo_reg;
    logic [AXIS_W-1:0]    d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [AXIS_W-1:0]   d_start;
    logic [AXIS_W-1:0]   p_start;
    logic [2*AXIS_W-1:0] num;
    logic                tiny;
    logic [AXIS_W:0]     s1;
    logic [AXIS_W:0]     s2;

    function automatic logic [AXIS_W:0] div_step(input logic [AXIS_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [AXIS_W-1:0] d);
        logic [AXIS_W:0] r2;
        logic [AXIS_W:0] diff;
        r2   = {rem, bit_in};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d})
        begin
            return {1'b1, diff[AXIS_W-1:0]};
        end
        return {1'b0, r2[AXIS_W-1:0]};
    endfunction

    assign tiny    = (req.size[AXIS_W-1:1] == '0);
    assign d_start = req.size - 1'b1;
    assign p_start = (req.pos >= req.size) ? d_start : req.pos;
    assign num     = {p_start, {AXIS_W{1'b0}}} - {{AXIS_W{1'b0}}, p_start};

    assign s1 = div_step(rem_reg, lo_reg[AXIS_W-1], d_reg);
    assign s2 = div_step(s1[AXIS_W-1:0], lo_reg[AXIS_W-2], d_reg);

    assign rsp.done = done_reg;
    assign rsp.quot = lo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            d_reg   <= d_start;
            rem_reg <= tiny ? '0 : num[2*AXIS_W-1:AXIS_W];
            lo_reg  <= tiny ? '0 : num[AXIS_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= s2[AXIS_W-1:0];
            lo_reg  <= {lo_reg[AXIS_W-3:0], s1[AXIS_W], s2[AXIS_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= !tiny;
                done_reg <= tiny;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/core/evtr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtr_back
// Sequencer that turns one queued command into its run of evdev words.
// ----------------------------------------------------------------------------
module evtr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_empty,
    input  evtr_pkg::cmd_t               cmd_in,
    output logic                         cmd_pop,
    input  logic [evtr_pkg::AXIS_W-1:0]  surface_width,
    input  logic [evtr_pkg::AXIS_W-1:0]  surface_height,
    input  logic                         out_full,
    output logic                         out_push,
    output evtr_pkg::out_word_t          out_word
);

    import evtr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY,
        S_KSYNC,
        S_XSTART,
        S_XWAIT,
        S_XEMIT,
        S_YSTART,
        S_YWAIT,
        S_YEMIT,
        S_BTN,
        S_WHEEL,
        S_MSYNC
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [BTN_N-1:0] pend_reg;

    div_req_t   div_req;
    div_rsp_t   div_rsp;
    logic [1:0] btn_idx;
    logic       emit;
    logic       step;

    evtr_axis_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign btn_idx = pend_reg[0] ? 2'd0 : (pend_reg[1] ? 2'd1 : 2'd2);
    assign cmd_pop = (state_reg == S_IDLE) && !cmd_empty;

    always_comb
    begin
        div_req.start = (state_reg == S_XSTART) || (state_reg == S_YSTART);
        div_req.pos   = (state_reg == S_YSTART) ? cmd_reg.pointer_y : cmd_reg.pointer_x;
        div_req.size  = (state_reg == S_YSTART) ? surface_height : surface_width;
    end

    always_comb
    begin
        emit                  = 1'b0;
        out_word.device_index = DEV_PTR;
        out_word.event_type   = EV_SYN;
        out_word.event_code   = CODE_SYN_REPORT;
        out_word.event_value  = '0;
        out_word.last_event   = 1'b0;
        unique case (state_reg)
            S_KEY:
            begin
                emit                  = 1'b1;
                out_word.device_index = DEV_KBD;
                out_word.event_type   = EV_KEY;
                out_word.event_code   = {{(CODE_W - KEY_W){1'b0}}, cmd_reg.key_code};
                out_word.event_value  = {{(VALUE_W - 1){1'b0}}, cmd_reg.key_press};
            end
            S_KSYNC:
            begin
                emit                  = 1'b1;
                out_word.device_index = DEV_KBD;
                out_word.last_event   = 1'b1;
            end
            S_XEMIT:
            begin
                emit                 = 1'b1;
                out_word.event_type  = EV_ABS;
                out_word.event_code  = CODE_ABS_X;
                out_word.event_value = {1'b0, div_rsp.quot};
            end
            S_YEMIT:
            begin
                emit                 = 1'b1;
                out_word.event_type  = EV_ABS;
                out_word.event_code  = CODE_ABS_Y;
                out_word.event_value = {1'b0, div_rsp.quot};
            end
            S_BTN:
            begin
                emit                 = (pend_reg != '0);
                out_word.event_type  = EV_KEY;
                out_word.event_code  = CODE_BTN_LEFT + {{(CODE_W - 2){1'b0}}, btn_idx};
                out_word.event_value = {{(VALUE_W - 1){1'b0}}, cmd_reg.buttons[btn_idx]};
            end
            S_WHEEL:
            begin
                emit                 = (cmd_reg.wheel != '0);
                out_word.event_type  = EV_REL;
                out_word.event_code  = CODE_REL_WHEEL;
                out_word.event_value = {{(VALUE_W - WHEEL_W){cmd_reg.wheel[WHEEL_W-1]}},
                                        cmd_reg.wheel};
            end
            S_MSYNC:
            begin
                emit                = 1'b1;
                out_word.last_event = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign out_push = emit && !out_full;
    assign step     = !emit || !out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cmd_reg   <= cmd_in;
                        pend_reg  <= cmd_in.changed;
                        state_reg <= cmd_in.is_mouse ? S_XSTART : S_KEY;
                    end
                end
                S_KEY:    if (step) state_reg <= S_KSYNC;
                S_KSYNC:  if (step) state_reg <= S_IDLE;
                S_XSTART: state_reg <= S_XWAIT;
                S_XWAIT:  if (div_rsp.done) state_reg <= S_XEMIT;
                S_XEMIT:  if (step) state_reg <= S_YSTART;
                S_YSTART: state_reg <= S_YWAIT;
                S_YWAIT:  if (div_rsp.done) state_reg <= S_YEMIT;
                S_YEMIT:  if (step) state_reg <= S_BTN;
                S_BTN:
                begin
                    if (pend_reg == '0)
                    begin
                        state_reg <= S_WHEEL;
                    end
                    else if (step)
                    begin
                        pend_reg <= pend_reg & ~BTN_N'(3'b001 << btn_idx);
                    end
                end
                S_WHEEL:  if (step) state_reg <= S_MSYNC;
                S_MSYNC:  if (step) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/evtr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evtr_checker
// Port-level checks on the result words of the translator.
// ----------------------------------------------------------------------------
module evtr_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 empty,
    input logic                                 pop,
    input logic                                 device_index,
    input logic [1:0]                           event_type,
    input logic [evtr_pkg::CODE_W-1:0]          event_code,
    input logic signed [evtr_pkg::VALUE_W-1:0]  event_value,
    input logic                                 last_event
);

    import evtr_pkg::*;

    // a keyboard run only carries key and sync words
    a_kbd_types: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && device_index == DEV_KBD) |-> (event_type == EV_SYN || event_type == EV_KEY))
        else $error("keyboard word with pointer event type");

    // sync closes every run and only sync does
    a_sync_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((event_type == EV_SYN) == last_event))
        else $error("last word flag does not match sync");

    // key and button states are zero or one
    a_key_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_type == EV_KEY) |-> (event_value == 17'sd0 || event_value == 17'sd1))
        else $error("key word value out of range");

    // a word waiting on pop stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(event_code) && $stable(event_value)
                              && $stable(event_type) && $stable(device_index)))
        else $error("result word changed while stalled");

endmodule

bind input_to_evdev_translator evtr_checker u_evtr_checker (.*);

@@ verif/input_to_evdev_translator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_to_evdev_translator_checker
// Watches the input, result and register channels of the translator. Every
// accepted input word is turned into the evdev event run it should cause.
// Each popped result word is compared field by field with the oldest
// predicted event. Register reads are compared with the shadow copy. The
// number of mismatches and of events still awaited go to the top.
// ----------------------------------------------------------------------------
module input_to_evdev_translator_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic                                 req_type,
    input  logic [evtr_pkg::SCAN_W-1:0]          scan_code,
    input  logic                                 key_press,
    input  logic [evtr_pkg::AXIS_W-1:0]          pointer_x,
    input  logic [evtr_pkg::AXIS_W-1:0]          pointer_y,
    input  logic [evtr_pkg::BTN_N-1:0]           button_mask,
    input  logic signed [evtr_pkg::WHEEL_W-1:0]  wheel_delta,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic                                 device_index,
    input  logic [1:0]                           event_type,
    input  logic [evtr_pkg::CODE_W-1:0]          event_code,
    input  logic signed [evtr_pkg::VALUE_W-1:0]  event_value,
    input  logic                                 last_event,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [evtr_pkg::ADDR_W-1:0]          paddr,
    input  logic [evtr_pkg::DATA_W-1:0]          pwdata,
    input  logic [evtr_pkg::DATA_W-1:0]          prdata,
    input  logic                                 pready,
    output int                                   failures,
    output int                                   pending
);

    import evtr_pkg::*;

    out_word_t          expected_events[$];
    logic [AXIS_W-1:0]  width_reg;
    logic [AXIS_W-1:0]  height_reg;
    logic [BTN_N-1:0]   held_buttons;
    out_word_t          want;

    function automatic void check_field(input string name, input logic signed [31:0] exp_val,
                                        input logic signed [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s expected %0d got %0d", name, exp_val, got_val);
            failures++;
        end
    endfunction

    function automatic logic [KEY_W-1:0] scan_to_key(input logic [SCAN_W-1:0] scan);
        logic [KEY_W-1:0] key;
        key = '0;
        if (scan >= 16'h0001 && scan <= 16'h0058)
        begin
            key = scan[KEY_W-1:0];
        end
        else if (scan[15:8] == 8'h00)
        begin
            case (scan[7:0])
                8'h70: key = 7'd93;
                8'h73: key = 7'd89;
                8'h79: key = 7'd92;
                8'h7B: key = 7'd94;
                8'h7D: key = 7'd124;
                default: key = '0;
            endcase
        end
        else if (scan[15:8] == 8'hE0)
        begin
            case (scan[7:0])
                8'h1C: key = 7'd96;
                8'h1D: key = 7'd97;
                8'h35: key = 7'd98;
                8'h37: key = 7'd99;
                8'h38: key = 7'd100;
                8'h47: key = 7'd102;
                8'h48: key = 7'd103;
                8'h49: key = 7'd104;
                8'h4B: key = 7'd105;
                8'h4D: key = 7'd106;
                8'h4F: key = 7'd107;
                8'h50: key = 7'd108;
                8'h51: key = 7'd109;
                8'h52: key = 7'd110;
                8'h53: key = 7'd111;
                8'h5B: key = 7'd125;
                8'h5C: key = 7'd126;
                8'h5D: key = 7'd127;
                default: key = '0;
            endcase
        end
        return key;
    endfunction

    // clamp to the last pixel, then stretch onto 0..65535
    function automatic logic [VALUE_W-1:0] scale_position(input logic [AXIS_W-1:0] pos,
                                                          input logic [AXIS_W-1:0] size);
        longint unsigned span;
        longint unsigned clamped;
        if (size <= 1)
        begin
            return '0;
        end
        span = size - 1;
        clamped = (pos >= size) ? span : pos;
        return VALUE_W'(clamped * 65535 / span);
    endfunction

    function automatic out_word_t make_event(input logic dev, input logic [1:0] kind,
                                             input logic [CODE_W-1:0] code,
                                             input logic [VALUE_W-1:0] value);
        out_word_t ev;
        ev.device_index = dev;
        ev.event_type   = kind;
        ev.event_code   = code;
        ev.event_value  = value;
        ev.last_event   = 1'b0;
        return ev;
    endfunction

    function automatic void predict_run(input logic kind, input logic [SCAN_W-1:0] scan,
                                        input logic down, input logic [AXIS_W-1:0] px,
                                        input logic [AXIS_W-1:0] py,
                                        input logic [BTN_N-1:0] btn,
                                        input logic signed [WHEEL_W-1:0] wheel);
        out_word_t         run[$];
        logic [KEY_W-1:0]  key;
        logic [BTN_N-1:0]  flips;
        if (kind == REQ_KBD)
        begin
            key = scan_to_key(scan);
            // unmapped code: nothing comes out
            if (key == '0)
            begin
                return;
            end
            run.push_back(make_event(DEV_KBD, EV_KEY, {2'b00, key}, {16'b0, down}));
            run.push_back(make_event(DEV_KBD, EV_SYN, CODE_SYN_REPORT, '0));
        end
        else
        begin
            run.push_back(make_event(DEV_PTR, EV_ABS, CODE_ABS_X, scale_position(px, width_reg)));
            run.push_back(make_event(DEV_PTR, EV_ABS, CODE_ABS_Y, scale_position(py, height_reg)));
            flips = btn ^ held_buttons;
            for (int i = 0; i < BTN_N; i++)
            begin
                if (flips[i])
                begin
                    run.push_back(make_event(DEV_PTR, EV_KEY, CODE_BTN_LEFT + 9'(i),
                                             {16'b0, btn[i]}));
                end
            end
            held_buttons = btn;
            if (wheel != 0)
            begin
                run.push_back(make_event(DEV_PTR, EV_REL, CODE_REL_WHEEL,
                                         {{9{wheel[7]}}, wheel}));
            end
            run.push_back(make_event(DEV_PTR, EV_SYN, CODE_SYN_REPORT, '0));
        end
        run[run.size()-1].last_event = 1'b1;
        foreach (run[i])
        begin
            expected_events.push_back(run[i]);
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg    = '0;
            height_reg   = '0;
            held_buttons = '0;
            expected_events.delete();
            failures     = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result word with nothing expected: code %0d value %0d",
                           event_code, event_value);
                    failures++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("device_index", 32'(want.device_index), 32'(device_index));
                    check_field("event_type", 32'(want.event_type), 32'(event_type));
                    check_field("event_code", 32'(want.event_code), 32'(event_code));
                    check_field("event_value", 32'($signed(want.event_value)),
                                32'(event_value));
                    check_field("last_event", 32'(want.last_event), 32'(last_event));
                end
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_WIDTH)
                    begin
                        width_reg = pwdata[AXIS_W-1:0];
                    end
                    else
                    begin
                        height_reg = pwdata[AXIS_W-1:0];
                    end
                end
                else
                begin
                    check_field("prdata",
                                {16'b0, (paddr[2] == REG_WIDTH) ? width_reg : height_reg},
                                prdata);
                end
            end
            if (push && !full)
            begin
                predict_run(req_type, scan_code, key_press, pointer_x, pointer_y,
                            button_mask, wheel_delta);
            end
        end
        pending = expected_events.size();
    end

endmodule

@@ verif/input_to_evdev_translator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_to_evdev_translator_tb
// Drives keyboard and mouse words into the translator with random gaps on
// both queue sides, sets the surface size through the register port between
// phases, and gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module input_to_evdev_translator_tb;

    import evtr_pkg::*;

    localparam int IDLE_GAP    = 100;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 67;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       push         = 1'b0;
    logic                       full;
    logic                       req_type     = 1'b0;
    logic [SCAN_W-1:0]          scan_code    = '0;
    logic                       key_press    = 1'b0;
    logic [AXIS_W-1:0]          pointer_x    = '0;
    logic [AXIS_W-1:0]          pointer_y    = '0;
    logic [BTN_N-1:0]           button_mask  = '0;
    logic signed [WHEEL_W-1:0]  wheel_delta  = '0;
    logic                       empty;
    logic                       pop          = 1'b0;
    logic                       device_index;
    logic [1:0]                 event_type;
    logic [CODE_W-1:0]          event_code;
    logic signed [VALUE_W-1:0]  event_value;
    logic                       last_event;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [ADDR_W-1:0]          paddr        = '0;
    logic [DATA_W-1:0]          pwdata       = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    int                         failures;
    int                         pending;

    logic                       steady        = 1'b0;
    int                         hold_requests = 0;
    logic [AXIS_W-1:0]          surf_w        = '0;
    logic [AXIS_W-1:0]          surf_h        = '0;

    input_to_evdev_translator u_dut (.*);

    input_to_evdev_translator_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("input_to_evdev_translator test failed");
        $finish;
    end

    task automatic offer_word();
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full);
        @(negedge clk);
    endtask

    // wait until every predicted event is out, then let the back end settle
    task automatic drain();
        push = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_surface(input logic [AXIS_W-1:0] w, input logic [AXIS_W-1:0] h);
        drain();
        reg_access(1'b1, {REG_WIDTH, 2'b00}, {16'($urandom), w});
        reg_access(1'b1, {REG_HEIGHT, 2'b00}, {16'($urandom), h});
        reg_access(1'b0, {REG_WIDTH, 2'b00}, DATA_W'($urandom));
        reg_access(1'b0, {REG_HEIGHT, 2'b00}, DATA_W'($urandom));
        surf_w = w;
        surf_h = h;
    endtask

    task automatic scramble_fields();
        scan_code   = SCAN_W'($urandom);
        key_press   = 1'($urandom);
        pointer_x   = AXIS_W'($urandom);
        pointer_y   = AXIS_W'($urandom);
        button_mask = BTN_N'($urandom);
        wheel_delta = WHEEL_W'($urandom);
    endtask

    task automatic key_word(input logic [SCAN_W-1:0] scan, input logic down);
        scramble_fields();
        req_type  = REQ_KBD;
        scan_code = scan;
        key_press = down;
        offer_word();
    endtask

    task automatic mouse_word(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                              input logic [BTN_N-1:0] btn,
                              input logic signed [WHEEL_W-1:0] wheel);
        scramble_fields();
        req_type    = REQ_MOUSE;
        pointer_x   = x;
        pointer_y   = y;
        button_mask = btn;
        wheel_delta = wheel;
        offer_word();
    endtask

    // mostly within or just past the surface, sometimes anywhere
    function automatic logic [AXIS_W-1:0] rand_pos(input logic [AXIS_W-1:0] size);
        int top;
        top = (size > 65533) ? 65535 : size + 2;
        if ($urandom_range(0, 3) == 0)
        begin
            return AXIS_W'($urandom);
        end
        return AXIS_W'($urandom_range(0, top));
    endfunction

    task automatic random_word();
        logic [SCAN_W-1:0] scan;
        if ($urandom_range(0, 1))
        begin
            mouse_word(rand_pos(surf_w), rand_pos(surf_h), BTN_N'($urandom),
                       $urandom_range(0, 1) ? WHEEL_W'(0) : WHEEL_W'($urandom));
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: scan = SCAN_W'($urandom_range(1, 16'h0058));
                3:       scan = SCAN_W'(16'h0070 + $urandom_range(0, 15));
                4, 5, 6: scan = SCAN_W'(16'hE000 | $urandom_range(16'h1C, 16'h5D));
                7:       scan = $urandom_range(0, 1) ? 16'h0000 : 16'h0059;
                default: scan = SCAN_W'($urandom);
            endcase
            key_word(scan, 1'($urandom));
        end
    endtask

    initial
    begin : result_sink
        int gap;
        int served;
        served = 0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_requests != served)
            begin
                served++;
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = steady ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                pop = 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (empty);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // surface sizes still zero from reset
        mouse_word(16'hFFFF, 16'hFFFF, 3'b111, 8'sd127);
        mouse_word(16'h0000, 16'h0000, 3'b000, -8'sd128);
        key_word(16'h0000, 1'b1);
        key_word(16'h0001, 1'b1);
        key_word(16'h0058, 1'b0);
        key_word(16'h0059, 1'b1);
        key_word(16'h0070, 1'b1);
        key_word(16'h007D, 1'b0);
        key_word(16'hE01C, 1'b1);
        key_word(16'hE05D, 1'b0);
        key_word(16'hE000, 1'b1);
        key_word(16'hFFFF, 1'b1);

        set_surface(16'd1, 16'd1);
        mouse_word(16'd5, 16'hFFFF, 3'b001, 8'sd0);

        set_surface(16'hFFFF, 16'hFFFF);
        mouse_word(16'hFFFF, 16'hFFFE, 3'b011, 8'sd1);
        mouse_word(16'h0000, 16'h7FFF, 3'b010, -8'sd1);

        set_surface(16'd2, 16'd3);
        mouse_word(16'd1, 16'd1, 3'b110, 8'sd0);
        mouse_word(16'd2, 16'd2, 3'b110, 8'sd0);
        // keyboard words leave the stored buttons alone
        key_word(16'h002A, 1'b1);
        mouse_word(16'd0, 16'd3, 3'b110, 8'sd64);
        mouse_word(16'd0, 16'd0, 3'b100, -8'sd5);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_surface(AXIS_W'($urandom_range(2, 64)), AXIS_W'($urandom_range(2, 64)));
                1: set_surface(16'hFFFF, 16'd1);
                2: set_surface(16'd0, 16'hFFFF);
                3: set_surface(AXIS_W'($urandom), AXIS_W'($urandom));
                4: set_surface(16'd2, 16'd2);
                default: set_surface(AXIS_W'($urandom_range(1, 2048)),
                                     AXIS_W'($urandom_range(1, 2048)));
            endcase
            steady = (phase == 2 || phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 8)
                begin
                    hold_requests++;
                end
                if (phase == 3 && n == 30)
                begin
                    drain();
                end
                random_word();
            end
        end

        drain();
        if (failures == 0 && pending == 0)
        begin
            $display("input_to_evdev_translator test passed");
        end
        else
        begin
            $display("input_to_evdev_translator test failed");
        end
        $finish;
    end

endmodule

@@ input_to_evdev_translator.f @@
rtl/core/evtr_pkg.sv
rtl/core/evtr_fifo.sv
rtl/core/evtr_front.sv
rtl/core/evtr_axis_div.sv
rtl/core/evtr_back.sv
rtl/core/input_to_evdev_translator.sv
rtl/core/evtr_checker.sv
verif/input_to_evdev_translator_checker.sv
verif/input_to_evdev_translator_tb.sv
